>>> rtl/core/tree_lca_binary_lifting_top_macros.svh
// Assertion macros shared by the checker of the ancestor engine.
// Each macro takes a label, a condition and a consequence sampled on clk.
`ifndef TREE_LCA_BINARY_LIFTING_TOP_MACROS_SVH
`define TREE_LCA_BINARY_LIFTING_TOP_MACROS_SVH

`define TLCA_CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlca check failed");

`define TLCA_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlca check failed");

`endif

>>> rtl/core/tlca_pkg.sv
// Shared constants, types and link helper for the ancestor engine.
// Used by the top level, the core and the checker; depends on nothing.
package tlca_pkg;

  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 11;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int LINK_W    = NODE_W + 1;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int ANC_DEPTH = LEVELS * MAX_NODES;
  localparam int ANC_AW    = $clog2(ANC_DEPTH);
  localparam int ST_W      = 2;
  localparam int IDX_W     = 2;

  localparam logic [ST_W-1:0] ST_UNKNOWN  = 2'd0;
  localparam logic [ST_W-1:0] ST_ATTACHED = 2'd1;
  localparam logic [ST_W-1:0] ST_DETACHED = 2'd2;
  localparam logic [ST_W-1:0] ST_ONPATH   = 2'd3;

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROOT_NODE  = 2'd1;

  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [NODE_W-1:0] root;
  } cfg_t;

  // A stored link counts only if it is set, points inside the used range
  // and does not belong to the root.
  function automatic logic [LINK_W-1:0] link_of(input logic [NODE_W-1:0] v,
                                                input logic [LINK_W-1:0] p,
                                                input cfg_t cfg);
    logic [LINK_W-1:0] r;
    r = p;
    if (v == cfg.root || !p[NODE_W] || {1'b0, p[NODE_W-1:0]} >= cfg.n) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/tree_lca_binary_lifting_top.sv
// Top level of the lowest common ancestor engine: registers, result stage, core.
// Depends on tlca_pkg and tlca_core.
//
// Input channel (in_valid/in_ready): one beat carries kind, node_a and node_b.
// An edge beat stores node_a as the parent of node_b.
// A query beat returns one result beat (ancestor, bad_query) on the output
// channel (out_valid/out_ready); edge beats return nothing.
// A query with valid tables first reads both depths, then walks the ancestor
// memory's single read port serially: eleven lifting steps, a compare that
// returns the result when the nodes meet after the depth lift, else eleven
// common steps, then a final parent read and the output register.
// A flagged query skips the walk; its result beat passes through the core's
// pending result register and then the output register.
// The first query after an edge load or a register write first rebuilds the
// tables: a status sweep over all 1024 nodes, a parent walk from each node,
// then a pass over every node per level for the ancestor table.
// Configuration beats (cfg_valid, cfg_index, cfg_data) are always taken.
// After reset the parent memory is cleared while in_ready is low.
// The result is held in an output register; while a beat stalls there the core
// holds the next result, and no input beat is taken until that one moves on.
module tree_lca_binary_lifting_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [tlca_pkg::NODE_W-1:0] node_a,
  input  logic [tlca_pkg::NODE_W-1:0] node_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tlca_pkg::NODE_W-1:0] ancestor,
  output logic                        bad_query,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tlca_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tlca_pkg::CNT_W-1:0]  cfg_data
);

  logic [tlca_pkg::CNT_W-1:0]  node_count;
  logic [tlca_pkg::NODE_W-1:0] root_node;
  tlca_pkg::cfg_t              cfg;
  logic                        cfg_stale;
  logic                        res_valid, res_ready, res_bad;
  logic [tlca_pkg::NODE_W-1:0] res_ancestor;

  assign cfg_ready = 1'b1;
  assign cfg_stale = cfg_valid && (cfg_index == tlca_pkg::REG_NODE_COUNT ||
                                   cfg_index == tlca_pkg::REG_ROOT_NODE);
  assign cfg.n = (node_count > tlca_pkg::CNT_W'(tlca_pkg::MAX_NODES)) ?
                 tlca_pkg::CNT_W'(tlca_pkg::MAX_NODES) : node_count;
  assign cfg.root = root_node;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= tlca_pkg::CNT_W'(tlca_pkg::MAX_NODES);
      root_node  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tlca_pkg::REG_NODE_COUNT: node_count <= cfg_data;
          tlca_pkg::REG_ROOT_NODE:  root_node  <= cfg_data[tlca_pkg::NODE_W-1:0];
          default: begin
          end
        endcase
      end
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
        ancestor  <= res_ancestor;
        bad_query <= res_bad;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  tlca_core u_core (
    .clk, .rst, .cfg, .cfg_stale,
    .in_valid, .in_ready, .kind, .node_a, .node_b,
    .res_valid, .res_ready, .res_ancestor, .res_bad
  );

endmodule

>>> rtl/core/tlca_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/tlca_core.sv
// Sequencer of the ancestor engine: parent, status, depth, stack and ancestor memories.
// Depends on tlca_pkg and tlca_ram.
module tlca_core (
  input  logic                       clk,
  input  logic                       rst,
  input  tlca_pkg::cfg_t             cfg,
  input  logic                       cfg_stale,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       kind,
  input  logic [tlca_pkg::NODE_W-1:0] node_a,
  input  logic [tlca_pkg::NODE_W-1:0] node_b,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [tlca_pkg::NODE_W-1:0] res_ancestor,
  output logic                       res_bad
);

  localparam int NW = tlca_pkg::NODE_W;
  localparam int CW = tlca_pkg::CNT_W;
  localparam int LW = tlca_pkg::LINK_W;
  localparam int KW = tlca_pkg::LVL_W;
  localparam int AW = tlca_pkg::ANC_AW;
  localparam int SW = tlca_pkg::ST_W;
  localparam logic [KW-1:0] TOP_LVL = KW'(tlca_pkg::LEVELS - 1);
  localparam logic [KW-1:0] LAST_BUILD = KW'(tlca_pkg::LEVELS - 2);

  typedef enum logic [23:0] {
    S_CLRP  = 24'h000001, S_IDLE  = 24'h000002, S_CLRS  = 24'h000004,
    S_ROOT  = 24'h000008, S_WRD   = 24'h000010, S_WEV   = 24'h000020,
    S_PCHK  = 24'h000040, S_PEV   = 24'h000080, S_L0RD  = 24'h000100,
    S_L0EV  = 24'h000200, S_LKRD  = 24'h000400, S_LKA   = 24'h000800,
    S_LKB   = 24'h001000, S_QD0   = 24'h002000, S_QD1   = 24'h004000,
    S_QD2   = 24'h008000, S_UPRD  = 24'h010000, S_UPEV  = 24'h020000,
    S_EQ    = 24'h040000, S_LURD  = 24'h080000, S_LUV   = 24'h100000,
    S_LUEV  = 24'h200000, S_FRD   = 24'h400000, S_FEV   = 24'h800000
  } state_t;

  state_t state;
  logic [CW-1:0] idx;
  logic [CW-1:0] len;
  logic [KW-1:0] kk;
  logic [NW-1:0] cur, base, qa, qb, du, dv;
  logic [LW-1:0] au;
  logic          att, tv;
  logic          out_pend;

  logic          p_we, s_we, d_we, k_we, a_we;
  logic [NW-1:0] p_wa, p_ra, s_wa, s_ra, d_wa, d_ra, k_wa, k_ra;
  logic [LW-1:0] p_wd, p_rd, a_wd, a_rd;
  logic [SW-1:0] s_wd, s_rd;
  logic [NW-1:0] d_wd, d_rd, k_wd, k_rd;
  logic [AW-1:0] a_wa, a_ra;

  logic [LW-1:0] lk_cur, lk_idx;
  logic [NW-1:0] diff, base_inc;
  logic [CW-1:0] step;
  logic          accept, last_v;

  tlca_ram #(.WIDTH(LW), .DEPTH(tlca_pkg::MAX_NODES)) u_parent (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  tlca_ram #(.WIDTH(SW), .DEPTH(tlca_pkg::MAX_NODES)) u_status (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  tlca_ram #(.WIDTH(NW), .DEPTH(tlca_pkg::MAX_NODES)) u_depth (
    .clk, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  tlca_ram #(.WIDTH(NW), .DEPTH(tlca_pkg::MAX_NODES)) u_stack (
    .clk, .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
  tlca_ram #(.WIDTH(LW), .DEPTH(tlca_pkg::ANC_DEPTH)) u_anc (
    .clk, .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));

  assign in_ready  = (state == S_IDLE) && !out_pend;
  assign accept    = in_valid && in_ready;
  assign res_valid = out_pend;
  assign lk_cur    = tlca_pkg::link_of(cur, p_rd, cfg);
  assign lk_idx    = tlca_pkg::link_of(idx[NW-1:0], p_rd, cfg);
  assign diff      = dv - du;
  assign step      = CW'(1) << kk;
  assign base_inc  = base + NW'(1);
  assign last_v    = (idx == cfg.n - CW'(1));

  always_comb begin
    p_we = 1'b0; p_wa = node_b;     p_wd = {1'b1, node_a}; p_ra = cur;
    s_we = 1'b0; s_wa = cur;        s_wd = tlca_pkg::ST_UNKNOWN; s_ra = cur;
    d_we = 1'b0; d_wa = k_rd;       d_wd = '0; d_ra = cur;
    k_we = 1'b0; k_wa = len[NW-1:0]; k_wd = cur; k_ra = NW'(len - CW'(1));
    a_we = 1'b0; a_wa = {kk, idx[NW-1:0]}; a_wd = '0; a_ra = {kk, idx[NW-1:0]};
    case (state)
      S_CLRP: begin
        p_we = 1'b1; p_wa = idx[NW-1:0]; p_wd = '0;
      end
      S_IDLE: begin
        p_we = accept && (kind == tlca_pkg::KIND_EDGE);
      end
      S_CLRS: begin
        s_we = 1'b1; s_wa = idx[NW-1:0];
      end
      S_ROOT: begin
        s_we = ({1'b0, cfg.root} < cfg.n); s_wa = cfg.root; s_wd = tlca_pkg::ST_ATTACHED;
        d_we = s_we; d_wa = cfg.root;
      end
      S_WEV: begin
        if (s_rd == tlca_pkg::ST_UNKNOWN && len < cfg.n) begin
          s_we = 1'b1; s_wd = tlca_pkg::ST_ONPATH;
          k_we = 1'b1;
        end
      end
      S_PEV: begin
        s_we = 1'b1; s_wa = k_rd; d_we = 1'b1;
        s_wd = att ? tlca_pkg::ST_ATTACHED : tlca_pkg::ST_DETACHED;
        d_wd = att ? base_inc : '0;
      end
      S_L0RD: begin
        s_ra = idx[NW-1:0]; p_ra = idx[NW-1:0];
      end
      S_L0EV: begin
        a_we = 1'b1; a_wa = {KW'(0), idx[NW-1:0]};
        a_wd = (s_rd == tlca_pkg::ST_ATTACHED) ? lk_idx : '0;
      end
      S_LKA: begin
        a_ra = {kk, a_rd[NW-1:0]};
      end
      S_LKB: begin
        a_we = 1'b1; a_wa = {kk + KW'(1), idx[NW-1:0]};
        a_wd = au[NW] ? a_rd : '0;
      end
      S_QD0:  d_ra = qa;
      S_QD1:  d_ra = qb;
      S_UPRD: a_ra = {kk, qb};
      S_LURD: a_ra = {kk, qa};
      S_LUV:  a_ra = {kk, qb};
      S_FRD:  a_ra = {KW'(0), qa};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLRP;
      idx      <= '0;
      tv       <= 1'b0;
      out_pend <= 1'b0;
    end else begin
      if (out_pend && res_ready) begin
        out_pend <= 1'b0;
      end
      if (cfg_stale) begin
        tv <= 1'b0;
      end
      case (state)
        S_CLRP: begin
          idx <= idx + CW'(1);
          if (idx == CW'(tlca_pkg::MAX_NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (kind == tlca_pkg::KIND_EDGE) begin
              tv <= 1'b0;
            end else begin
              qa <= node_a;
              qb <= node_b;
              if ({1'b0, node_a} >= cfg.n || {1'b0, node_b} >= cfg.n) begin
                res_ancestor <= '0;
                res_bad      <= 1'b1;
                out_pend     <= 1'b1;
              end else begin
                res_bad <= 1'b0;
                idx     <= '0;
                state   <= tv ? S_QD0 : S_CLRS;
              end
            end
          end
        end
        S_CLRS: begin
          idx <= idx + CW'(1);
          if (idx == CW'(tlca_pkg::MAX_NODES - 1)) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          idx   <= '0;
          cur   <= '0;
          len   <= '0;
          state <= S_WRD;
        end
        S_WRD: state <= S_WEV;
        S_WEV: begin
          if (s_rd == tlca_pkg::ST_UNKNOWN && len < cfg.n) begin
            len <= len + CW'(1);
            if (!lk_cur[NW]) begin
              att   <= 1'b0;
              state <= S_PCHK;
            end else begin
              cur   <= lk_cur[NW-1:0];
              state <= S_WRD;
            end
          end else begin
            att   <= (s_rd == tlca_pkg::ST_ATTACHED);
            base  <= d_rd;
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (len == '0) begin
            if (last_v) begin
              idx   <= '0;
              state <= S_L0RD;
            end else begin
              idx   <= idx + CW'(1);
              cur   <= NW'(idx + CW'(1));
              state <= S_WRD;
            end
          end else begin
            len   <= len - CW'(1);
            state <= S_PEV;
          end
        end
        S_PEV: begin
          if (att) begin
            base <= base_inc;
          end
          state <= S_PCHK;
        end
        S_L0RD: state <= S_L0EV;
        S_L0EV: begin
          if (last_v) begin
            idx   <= '0;
            kk    <= '0;
            state <= S_LKRD;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_L0RD;
          end
        end
        S_LKRD: state <= S_LKA;
        S_LKA: begin
          au    <= a_rd;
          state <= S_LKB;
        end
        S_LKB: begin
          if (last_v) begin
            idx <= '0;
            if (kk == LAST_BUILD) begin
              tv    <= 1'b1;
              state <= S_QD0;
            end else begin
              kk    <= kk + KW'(1);
              state <= S_LKRD;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= S_LKRD;
          end
        end
        S_QD0: state <= S_QD1;
        S_QD1: begin
          du    <= d_rd;
          state <= S_QD2;
        end
        S_QD2: begin
          if (du > d_rd) begin
            qa <= qb;
            qb <= qa;
            du <= d_rd;
            dv <= du;
          end else begin
            dv <= d_rd;
          end
          kk    <= TOP_LVL;
          state <= S_UPRD;
        end
        S_UPRD: state <= S_UPEV;
        S_UPEV: begin
          if (dv >= du && {1'b0, diff} >= step && a_rd[NW]) begin
            qb <= a_rd[NW-1:0];
            dv <= dv - step[NW-1:0];
          end
          if (kk == '0) begin
            state <= S_EQ;
          end else begin
            kk    <= kk - KW'(1);
            state <= S_UPRD;
          end
        end
        S_EQ: begin
          if (qa == qb) begin
            res_ancestor <= qa;
            out_pend     <= 1'b1;
            state        <= S_IDLE;
          end else begin
            kk    <= TOP_LVL;
            state <= S_LURD;
          end
        end
        S_LURD: state <= S_LUV;
        S_LUV: begin
          au    <= a_rd;
          state <= S_LUEV;
        end
        S_LUEV: begin
          if (au != a_rd && au[NW] && a_rd[NW]) begin
            qa <= au[NW-1:0];
            qb <= a_rd[NW-1:0];
          end
          if (kk == '0) begin
            state <= S_FRD;
          end else begin
            kk    <= kk - KW'(1);
            state <= S_LURD;
          end
        end
        S_FRD: state <= S_FEV;
        S_FEV: begin
          res_ancestor <= a_rd[NW] ? a_rd[NW-1:0] : '0;
          out_pend     <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/tlca_checker.sv
// Port-level checks of the ancestor engine, bound to the top level.
// Depends on tlca_pkg and the assertion macro header.
`include "tree_lca_binary_lifting_top_macros.svh"

module tlca_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        kind,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tlca_pkg::NODE_W-1:0] ancestor,
  input logic                        bad_query
);

  `TLCA_CHK_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(ancestor))
  `TLCA_CHK_SAME(a_bad_zero, out_valid && bad_query, ancestor == '0)
  `TLCA_CHK_NEXT(a_busy, in_valid && in_ready && kind == tlca_pkg::KIND_QUERY, !in_ready)
  `TLCA_CHK_SAME(a_clear, $past(rst), !in_ready)

endmodule

bind tree_lca_binary_lifting_top tlca_checker u_tlca_checker (.*);
